FILE: rtl/core/prime_sum_upto_top_macros.svh
// assertion macros used by the datapath
`ifndef PRIME_SUM_UPTO_TOP_MACROS_SVH
`define PRIME_SUM_UPTO_TOP_MACROS_SVH

// condition holds in the same cycle as the trigger
`define PSU_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("psu assertion failed");

// condition holds in the cycle after the trigger
`define PSU_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("psu assertion failed");

`endif

FILE: rtl/core/psu_pkg.sv
package psu_pkg;

  // width of the result field
  localparam int SUM_BITS = 28;

  // first candidate of the sieve
  localparam int FIRST_PRIME = 2;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_CHECK,
    ST_MARK,
    ST_FIN
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic clr_wr;
    logic i_init;
    logic i_step;
    logic add_sum;
    logic k_init;
    logic mark_wr;
    logic out_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic n_lt2;
    logic is_comp;
    logic sq_le_n;
    logic i_last;
    logic k_last;
    logic out_busy;
  } stat_t;

endpackage

FILE: rtl/core/prime_sum_upto_top.sv
// each query with bound n >= 2 runs a clearing pass over the flags 0 to n, a read and a
// check of each candidate from 2 to n, one strike of the sieve at a time, and a result load
// one transaction at a time; the load waits while an earlier result is stalled
// synchronous active-low reset clears the controller and the result valid flag;
// the flag memory is cleared by each query for its own range
module prime_sum_upto_top #(
  parameter int BOUND_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [BOUND_BITS-1:0]         in_upper_bound,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [psu_pkg::SUM_BITS-1:0]  out_prime_sum
);
  import psu_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  psu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // sieve memory, counters and result register
  psu_dpath #(
    .BOUND_BITS (BOUND_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_upper_bound (in_upper_bound),
    .cmd            (cmd),
    .stat           (stat),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_prime_sum  (out_prime_sum)
  );

endmodule

FILE: rtl/core/psu_ctrl.sv
module psu_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  psu_pkg::stat_t stat,
  output psu_pkg::cmd_t  cmd
);
  import psu_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (stat.clr_last) state_nxt = stat.n_lt2 ? ST_FIN : ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (!stat.is_comp && stat.sq_le_n) state_nxt = ST_MARK;
        else if (stat.i_last)              state_nxt = ST_FIN;
        else                               state_nxt = ST_READ;
      end
      ST_MARK: begin
        if (stat.k_last) state_nxt = stat.i_last ? ST_FIN : ST_READ;
      end
      ST_FIN: begin
        if (!stat.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        cmd.i_init = stat.clr_last;
      end
      ST_READ: begin
        cmd = '0;
      end
      ST_CHECK: begin
        cmd.add_sum = !stat.is_comp;
        cmd.k_init  = !stat.is_comp && stat.sq_le_n;
        cmd.i_step  = (stat.is_comp || !stat.sq_le_n) && !stat.i_last;
      end
      ST_MARK: begin
        cmd.mark_wr = 1'b1;
        cmd.i_step  = stat.k_last && !stat.i_last;
      end
      ST_FIN: begin
        cmd.out_load = !stat.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: rtl/core/psu_dpath.sv
`include "prime_sum_upto_top_macros.svh"

module psu_dpath #(
  parameter int BOUND_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [BOUND_BITS-1:0]         in_upper_bound,
  input  psu_pkg::cmd_t                 cmd,
  output psu_pkg::stat_t                stat,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [psu_pkg::SUM_BITS-1:0]  out_prime_sum
);
  import psu_pkg::*;

  localparam int DEPTH = 1 << BOUND_BITS;

  logic [BOUND_BITS-1:0]   n_r;
  logic [BOUND_BITS-1:0]   c_r;
  logic [BOUND_BITS-1:0]   i_r;
  logic [BOUND_BITS:0]     k_r;
  logic [2*BOUND_BITS-1:0] sq_r;
  logic                    rd_r;
  logic [SUM_BITS-1:0]     sum_r;
  logic [SUM_BITS:0]       sum_add;
  logic [SUM_BITS-1:0]     sum_nxt;
  logic [BOUND_BITS:0]     k_sum;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic [SUM_BITS-1:0]     out_sum_r;
  logic                    mem_we;
  logic [BOUND_BITS-1:0]   mem_waddr;
  logic                    mem_wdata;

  // composite flags, one bit per value
  logic mem [0:DEPTH-1];

  // saturating accumulate of the current prime
  assign sum_add = {1'b0, sum_r} + (SUM_BITS+1)'(i_r);
  assign sum_nxt = sum_add[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_add[SUM_BITS-1:0];

  // next multiple to strike
  assign k_sum = k_r + (BOUND_BITS+1)'(i_r);

  // memory write port: clearing pass or strike
  assign mem_we    = cmd.clr_wr || cmd.mark_wr;
  assign mem_waddr = cmd.clr_wr ? c_r : k_r[BOUND_BITS-1:0];
  assign mem_wdata = cmd.mark_wr;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_r <= mem[i_r];
  end

  // square of the candidate, registered before the compare
  always_ff @(posedge clk) begin
    sq_r <= (2*BOUND_BITS)'(i_r) * (2*BOUND_BITS)'(i_r);
  end

  // counters and accumulator
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r   <= in_upper_bound;
      c_r   <= '0;
      sum_r <= '0;
    end else begin
      if (cmd.clr_wr)  c_r   <= c_r + BOUND_BITS'(1);
      if (cmd.add_sum) sum_r <= sum_nxt;
    end
    if (cmd.i_init)      i_r <= BOUND_BITS'(FIRST_PRIME);
    else if (cmd.i_step) i_r <= i_r + BOUND_BITS'(1);
    if (cmd.k_init)       k_r <= sq_r[BOUND_BITS:0];
    else if (cmd.mark_wr) k_r <= k_sum;
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.out_load)             out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_sum_r <= sum_r;
  end

  assign out_valid     = out_valid_r;
  assign out_prime_sum = out_sum_r;

  // status to the controller
  always_comb begin
    stat.clr_last = (c_r == n_r);
    stat.n_lt2    = (n_r < BOUND_BITS'(FIRST_PRIME));
    stat.is_comp  = rd_r;
    stat.sq_le_n  = (sq_r <= (2*BOUND_BITS)'(n_r));
    stat.i_last   = (i_r == n_r);
    stat.k_last   = (k_sum > (BOUND_BITS+1)'(n_r));
    stat.out_busy = out_valid_r && !out_ready;
  end

  // strikes stay above the candidate and within the bound
  `PSU_ASSERT_NOW(a_mark_above_i, clk, rst_n, cmd.mark_wr, k_r > (BOUND_BITS+1)'(i_r))
  `PSU_ASSERT_NOW(a_mark_in_range, clk, rst_n, cmd.mark_wr, k_r <= (BOUND_BITS+1)'(n_r))
  // clearing pass never runs past the bound
  `PSU_ASSERT_NOW(a_clear_in_range, clk, rst_n, cmd.clr_wr, c_r <= n_r)
  // a loaded result is offered in the next cycle
  `PSU_ASSERT_NEXT(a_out_loaded, clk, rst_n, cmd.out_load, out_valid_r)

endmodule
